/* hdl/nurbs_curve_point_evaluator_assert.svh */
// assertion macros for the curve point evaluator
`ifndef NURBS_CURVE_POINT_EVALUATOR_ASSERT_SVH
`define NURBS_CURVE_POINT_EVALUATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NCPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define NCPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ncpe_pkg.sv */
package ncpe_pkg;

  localparam int MAX_POLES  = 64;
  localparam int MAX_DEGREE = 7;
  localparam int DVD_W      = 60;
  localparam int DVS_W      = 28;

  localparam logic [16:0] U_ONE     = 17'h10000;
  localparam logic [30:0] BASIS_ONE = 31'h40000000;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_POLES  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  pole_index;
    logic [31:0] pole_x;
    logic [31:0] pole_y;
    logic [23:0] pole_weight;
    logic [16:0] eval_u;
  } ncpe_in_t;

  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [5:0]  span_index;
  } ncpe_out_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_STORE, OP_LOAD, OP_SPAN, OP_KNOT_GO, OP_KNOT_WR,
    OP_B_INIT, OP_B_RD, OP_B_MULR, OP_DIV, OP_B_WRN, OP_B_MULL,
    OP_B_WRS, OP_B_LAST, OP_A_RD, OP_A_NW, OP_A_MUL, OP_A_ADD,
    OP_F_GO, OP_F_WR
  } ncpe_op_t;

  typedef enum logic [1:0] {
    DIV_KNOT, DIV_BASIS, DIV_FINAL
  } ncpe_div_mode_t;

  typedef struct packed {
    ncpe_op_t   op;
    logic [2:0] j;
    logic [2:0] r;
    logic [2:0] k;
    logic       side;
  } ncpe_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic [2:0] eff_deg;
  } ncpe_sts_t;

endpackage

/* hdl/ncpe_div.sv */
module ncpe_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  ncpe_pkg::ncpe_div_mode_t        mode,
  input  logic [ncpe_pkg::DVD_W-1:0]      dividend,
  input  logic [ncpe_pkg::DVS_W-1:0]      divisor,
  output logic                            done,
  output logic [ncpe_pkg::DVD_W-1:0]      quot
);
  import ncpe_pkg::*;

  logic [DVS_W-1:0] rem_r, rem_nxt, rem_init;
  logic [DVD_W-1:0] q_r, q_nxt, q_init;
  logic [DVS_W-1:0] dvs_r;
  logic [5:0]       cnt_r, cnt_init;
  logic             run_r, done_r;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  // restoring step, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, q_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  // quotient width per mode sets how many bits get walked
  always_comb begin
    case (mode)
      DIV_KNOT: begin
        rem_init = dividend[43:16];
        q_init   = {dividend[15:0], 44'd0};
        cnt_init = 6'd15;
      end
      DIV_BASIS: begin
        rem_init = dividend[58:31];
        q_init   = {dividend[30:0], 29'd0};
        cnt_init = 6'd30;
      end
      default: begin
        rem_init = '0;
        q_init   = dividend;
        cnt_init = 6'd59;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 6'd0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      q_r   <= q_init;
      dvs_r <= divisor;
      cnt_r <= cnt_init;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign done = done_r;
  assign quot = (dvs_r == '0) ? '0 : q_r;

endmodule

/* hdl/ncpe_ctrl.sv */
module ncpe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 opcode,
  input  ncpe_pkg::ncpe_sts_t  sts,
  output ncpe_pkg::ncpe_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import ncpe_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001, S_SPAN   = 20'h00002, S_KGO    = 20'h00004,
    S_KWAIT  = 20'h00008, S_BINIT  = 20'h00010, S_BRD    = 20'h00020,
    S_BMULR  = 20'h00040, S_BDIVR  = 20'h00080, S_BWAITR = 20'h00100,
    S_BMULL  = 20'h00200, S_BDIVL  = 20'h00400, S_BWAITL = 20'h00800,
    S_BLAST  = 20'h01000, S_ARD    = 20'h02000, S_ANW    = 20'h04000,
    S_AMUL   = 20'h08000, S_AADD   = 20'h10000, S_FGO    = 20'h20000,
    S_FWAIT  = 20'h40000, S_OUT    = 20'h80000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] j_r, j_nxt, r_r, r_nxt, k_r, k_nxt;
  logic       side_r, side_nxt;
  ncpe_op_t   op;
  logic [2:0] p;

  assign p = sts.eff_deg;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    side_nxt  = side_r;
    op        = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (opcode) begin
            op        = OP_LOAD;
            state_nxt = S_SPAN;
          end else begin
            op = OP_STORE;
          end
        end
      end
      S_SPAN: begin
        op        = OP_SPAN;
        j_nxt     = 3'd1;
        side_nxt  = 1'b0;
        state_nxt = (p == 3'd0) ? S_BINIT : S_KGO;
      end
      S_KGO: begin
        op        = OP_KNOT_GO;
        state_nxt = S_KWAIT;
      end
      S_KWAIT: begin
        if (sts.div_done) begin
          op = OP_KNOT_WR;
          if (!side_r) begin
            side_nxt  = 1'b1;
            state_nxt = S_KGO;
          end else if (j_r == p) begin
            state_nxt = S_BINIT;
          end else begin
            j_nxt     = j_r + 3'd1;
            side_nxt  = 1'b0;
            state_nxt = S_KGO;
          end
        end
      end
      S_BINIT: begin
        op        = OP_B_INIT;
        j_nxt     = 3'd1;
        r_nxt     = 3'd0;
        k_nxt     = 3'd0;
        state_nxt = (p == 3'd0) ? S_ARD : S_BRD;
      end
      S_BRD: begin
        op        = OP_B_RD;
        state_nxt = S_BMULR;
      end
      S_BMULR: begin
        op        = OP_B_MULR;
        state_nxt = S_BDIVR;
      end
      S_BDIVR: begin
        op        = OP_DIV;
        state_nxt = S_BWAITR;
      end
      S_BWAITR: begin
        if (sts.div_done) begin
          op        = OP_B_WRN;
          state_nxt = S_BMULL;
        end
      end
      S_BMULL: begin
        op        = OP_B_MULL;
        state_nxt = S_BDIVL;
      end
      S_BDIVL: begin
        op        = OP_DIV;
        state_nxt = S_BWAITL;
      end
      S_BWAITL: begin
        if (sts.div_done) begin
          op = OP_B_WRS;
          if (r_r == j_r - 3'd1) begin
            state_nxt = S_BLAST;
          end else begin
            r_nxt     = r_r + 3'd1;
            state_nxt = S_BRD;
          end
        end
      end
      S_BLAST: begin
        op = OP_B_LAST;
        if (j_r == p) begin
          state_nxt = S_ARD;
        end else begin
          j_nxt     = j_r + 3'd1;
          r_nxt     = 3'd0;
          state_nxt = S_BRD;
        end
      end
      S_ARD: begin
        op        = OP_A_RD;
        state_nxt = S_ANW;
      end
      S_ANW: begin
        op        = OP_A_NW;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        op        = OP_A_MUL;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        op = OP_A_ADD;
        if (k_r == p) begin
          side_nxt  = 1'b0;
          state_nxt = S_FGO;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_ARD;
        end
      end
      S_FGO: begin
        op        = OP_F_GO;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          op = OP_F_WR;
          if (side_r) begin
            state_nxt = S_OUT;
          end else begin
            side_nxt  = 1'b1;
            state_nxt = S_FGO;
          end
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= 3'd0;
      r_r     <= 3'd0;
      k_r     <= 3'd0;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      r_r     <= r_nxt;
      k_r     <= k_nxt;
      side_r  <= side_nxt;
    end
  end

  assign cmd.op    = op;
  assign cmd.j     = j_r;
  assign cmd.r     = r_r;
  assign cmd.k     = k_r;
  assign cmd.side  = side_r;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

/* hdl/ncpe_dp.sv */
module ncpe_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ncpe_pkg::ncpe_cmd_t  cmd,
  input  ncpe_pkg::ncpe_in_t   in_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  output ncpe_pkg::ncpe_sts_t  sts,
  output ncpe_pkg::ncpe_out_t  out_data
);
  import ncpe_pkg::*;

  // configuration
  logic [2:0] cfg_deg_r;
  logic [6:0] cfg_cnt_r;
  logic [6:0] n_eff, m_eff;
  logic [2:0] p_eff;

  // pole memory
  logic [31:0] mem_x [MAX_POLES];
  logic [31:0] mem_y [MAX_POLES];
  logic [23:0] mem_w [MAX_POLES];
  logic signed [31:0] px_q_r, py_q_r;
  logic [23:0] pw_q_r;

  // evaluation state
  logic [16:0] u_r;
  logic [5:0]  span_r;
  logic [16:0] lft_r [8];
  logic [16:0] rgt_r [8];
  logic [30:0] basis_r [8];
  logic [30:0] saved_r, op_n_r;
  logic [16:0] op_rgt_r, op_lft_r;
  logic [47:0] prod_r;
  logic [17:0] den_r;
  logic        kn_lo_r, kn_hi_r, fneg_r;
  logic [23:0] nw_r;
  logic [27:0] wsum_r;
  logic signed [56:0] mx_r, my_r;
  logic signed [59:0] sx_r, sy_r;
  ncpe_out_t   out_r;

  // combinational helpers
  logic [24:0] spm, spq;
  logic [6:0]  kidx;
  logic        kn_lo, kn_hi;
  logic [16:0] knot;
  logic [54:0] nw_full;
  logic signed [59:0] fsum;
  logic [59:0] fmag;
  logic [31:0] sat;
  logic [2:0]  ri1, jmr;

  logic        div_start, div_done;
  ncpe_div_mode_t div_mode;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  always_comb begin
    if (cfg_cnt_r < 7'd2) begin
      n_eff = 7'd2;
    end else if (cfg_cnt_r > 7'(MAX_POLES)) begin
      n_eff = 7'(MAX_POLES);
    end else begin
      n_eff = cfg_cnt_r;
    end
    p_eff = ({4'd0, cfg_deg_r} > n_eff - 7'd1) ? 3'(n_eff - 7'd1) : cfg_deg_r;
    m_eff = n_eff - {4'd0, p_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_deg_r <= 3'd3;
      cfg_cnt_r <= 7'd4;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEGREE) begin
        cfg_deg_r <= cfg_data[2:0];
      end else begin
        cfg_cnt_r <= cfg_data;
      end
    end
  end

  always_comb begin
    // span: last index k with knot k <= u, closed form of the uniform knots
    spm  = 25'({1'b0, u_r} + 18'd1) * 25'(m_eff);
    spq  = spm - 25'd1;
    // knot index for left (side 0) or right (side 1) distance
    kidx  = cmd.side ? 7'({1'b0, span_r} + {4'd0, cmd.j})
                     : 7'({1'b0, span_r} + 7'd1 - {4'd0, cmd.j});
    kn_lo = kidx <= {4'd0, p_eff};
    kn_hi = kidx >= n_eff;
    if (kn_lo_r) begin
      knot = '0;
    end else if (kn_hi_r) begin
      knot = U_ONE;
    end else begin
      knot = div_q[16:0];
    end
    ri1     = cmd.r + 3'd1;
    jmr     = cmd.j - cmd.r;
    nw_full = {24'd0, op_n_r} * {31'd0, pw_q_r};
    fsum    = cmd.side ? sy_r : sx_r;
    fmag    = fsum[59] ? 60'(-fsum) : 60'(fsum);
    // round to nearest, ties away, then saturate
    if (fneg_r) begin
      sat = (|div_q[59:32] || div_q[31:0] > 32'h80000000) ? 32'h80000000
                                                           : 32'd0 - div_q[31:0];
    end else begin
      sat = (|div_q[59:31]) ? 32'h7fffffff : div_q[31:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_mode  = DIV_FINAL;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (cmd.op)
      OP_KNOT_GO: begin
        div_start = 1'b1;
        div_mode  = DIV_KNOT;
        div_dvd   = (kn_lo || kn_hi) ? '0
                    : {38'd0, 6'(kidx - {4'd0, p_eff}), 16'd0};
        div_dvs   = {21'd0, m_eff};
      end
      OP_DIV: begin
        div_start = 1'b1;
        div_mode  = DIV_BASIS;
        div_dvd   = {12'd0, prod_r};
        div_dvs   = {10'd0, den_r};
      end
      OP_F_GO: begin
        div_start = 1'b1;
        div_mode  = DIV_FINAL;
        div_dvd   = fmag + {33'd0, wsum_r[27:1]};
        div_dvs   = wsum_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ncpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .mode     (div_mode),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && {1'b0, in_data.pole_index} < n_eff) begin
      mem_x[in_data.pole_index] <= in_data.pole_x;
      mem_y[in_data.pole_index] <= in_data.pole_y;
      mem_w[in_data.pole_index] <= in_data.pole_weight;
    end
    if (cmd.op == OP_A_RD) begin
      px_q_r <= mem_x[6'(span_r - {3'd0, p_eff} + {3'd0, cmd.k})];
      py_q_r <= mem_y[6'(span_r - {3'd0, p_eff} + {3'd0, cmd.k})];
      pw_q_r <= mem_w[6'(span_r - {3'd0, p_eff} + {3'd0, cmd.k})];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        u_r <= (in_data.eval_u > U_ONE) ? U_ONE : in_data.eval_u;
      end
      OP_SPAN: begin
        span_r <= (u_r == U_ONE) ? 6'(n_eff - 7'd1) : 6'({3'd0, p_eff} + spq[21:16]);
      end
      OP_KNOT_GO: begin
        kn_lo_r <= kn_lo;
        kn_hi_r <= kn_hi;
      end
      OP_KNOT_WR: begin
        if (cmd.side) begin
          rgt_r[cmd.j] <= (knot > u_r) ? knot - u_r : '0;
        end else begin
          lft_r[cmd.j] <= (u_r > knot) ? u_r - knot : '0;
        end
      end
      OP_B_INIT: begin
        basis_r[0] <= BASIS_ONE;
        saved_r    <= '0;
        wsum_r     <= '0;
        sx_r       <= '0;
        sy_r       <= '0;
      end
      OP_B_RD: begin
        op_rgt_r <= rgt_r[ri1];
        op_lft_r <= lft_r[jmr];
        op_n_r   <= basis_r[cmd.r];
      end
      OP_B_MULR: begin
        prod_r <= {17'd0, op_n_r} * {31'd0, op_rgt_r};
        den_r  <= {1'b0, op_rgt_r} + {1'b0, op_lft_r};
      end
      OP_B_WRN: begin
        basis_r[cmd.r] <= saved_r + div_q[30:0];
      end
      OP_B_MULL: begin
        prod_r <= {17'd0, op_n_r} * {31'd0, op_lft_r};
      end
      OP_B_WRS: begin
        saved_r <= div_q[30:0];
      end
      OP_B_LAST: begin
        basis_r[cmd.j] <= saved_r;
        saved_r        <= '0;
      end
      OP_A_RD: begin
        op_n_r <= basis_r[cmd.k];
      end
      OP_A_NW: begin
        nw_r <= nw_full[53:30];
      end
      OP_A_MUL: begin
        mx_r   <= $signed({1'b0, nw_r}) * px_q_r;
        my_r   <= $signed({1'b0, nw_r}) * py_q_r;
        wsum_r <= wsum_r + {4'd0, nw_r};
      end
      OP_A_ADD: begin
        sx_r <= sx_r + {{3{mx_r[56]}}, mx_r};
        sy_r <= sy_r + {{3{my_r[56]}}, my_r};
      end
      OP_F_GO: begin
        fneg_r <= fsum[59];
      end
      OP_F_WR: begin
        if (cmd.side) begin
          out_r.point_y <= sat;
        end else begin
          out_r.point_x <= sat;
        end
        out_r.span_index <= span_r;
      end
      default: begin
      end
    endcase
  end

  assign sts.div_done = div_done;
  assign sts.eff_deg  = p_eff;
  assign out_data     = out_r;

endmodule

/* hdl/nurbs_curve_point_evaluator.sv */
// nurbs curve point evaluator: a transfer with opcode 0 stores one pole (x, y, weight)
// and the block stays free; a transfer with opcode 1 evaluates the clamped uniform
// planar rational b-spline at u and raises busy until the point is shown. every knot,
// basis and final division runs on the shared divider, which retires one quotient
// bit per cycle. the result sits on out_data for exactly one cycle with out_valid
// high and the receiver cannot stall it, so it must be captured in that cycle.
// configuration writes take effect at once and belong in idle time only. poles never
// stored since reset read as garbage.
`include "nurbs_curve_point_evaluator_assert.svh"

module nurbs_curve_point_evaluator (
  input  logic                 clk,
  input  logic                 rst_n,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  ncpe_pkg::ncpe_in_t   in_data,
  // result side, one-cycle strobe
  output logic                 out_valid,
  output ncpe_pkg::ncpe_out_t  out_data,
  // register writes
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data
);
  import ncpe_pkg::*;

  ncpe_cmd_t cmd;
  ncpe_sts_t sts;
  logic      start_ok;

  // a transfer only when the sequencer is idle
  assign start_ok = start && !busy;

  // sequencer: walks span, knots, basis recurrence, pole sums, final divide
  ncpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_ok),
    .opcode    (in_data.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: pole memory, recurrence registers, multipliers, divider
  ncpe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_data  (out_data)
  );

  `NCPE_ASSERT_NXT(a_eval_busy, start && !busy && in_data.opcode, busy, "evaluate not started")
  `NCPE_ASSERT_NXT(a_store_free, start && !busy && !in_data.opcode, !busy, "store held block")
  `NCPE_ASSERT_NXT(a_out_ends, out_valid, !busy && !out_valid, "strobe not followed by idle")
  `NCPE_ASSERT_IMP(a_out_busy, out_valid, busy, "result outside evaluation")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ncpe_pkg::*;

  localparam logic OPC_STORE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   ITEM_TARGET   = 1150;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t  kind;
    ncpe_in_t   item;
    logic       cfg_idx;
    logic [6:0] cfg_val;
  } pend_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ncpe_in_t  in_data;
  logic      out_valid;
  ncpe_out_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [6:0] cfg_data;

  nurbs_curve_point_evaluator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // curve predictor: own copy of the registers, poles and knots
  // ---------------------------------------------------------------
  logic [2:0]      mdl_degree;
  logic [6:0]      mdl_count;
  longint          pole_x_mem [MAX_POLES];
  longint          pole_y_mem [MAX_POLES];
  longint unsigned pole_w_mem [MAX_POLES];
  longint unsigned knot_tab [MAX_POLES + MAX_DEGREE + 1];

  pend_t     pend_q[$];
  ncpe_out_t point_q[$];
  int        mismatches;
  int        fail_cnt;

  function automatic int clamp_count(logic [6:0] cnt);
    if (cnt < 2) return 2;
    if (cnt > MAX_POLES) return MAX_POLES;
    return int'(cnt);
  endfunction

  function automatic int clamp_degree(logic [2:0] deg, int n);
    int d;
    d = int'(deg);
    if (d > MAX_DEGREE) d = MAX_DEGREE;
    if (d > n - 1) d = n - 1;
    return d;
  endfunction

  // clamped uniform knot vector
  task automatic rebuild_knots();
    int n;
    int p;
    n = clamp_count(mdl_count);
    p = clamp_degree(mdl_degree, n);
    foreach (knot_tab[k]) knot_tab[k] = 0;
    for (int k = 0; k <= n + p && k < MAX_POLES + MAX_DEGREE + 1; k++) begin
      if (k <= p) knot_tab[k] = 0;
      else if (k >= n) knot_tab[k] = 65536;
      else knot_tab[k] = (longint'(k - p) * 65536) / longint'(n - p);
    end
  endtask

  // rounded quotient, ties away from zero, saturated to 32 bits
  function automatic logic [31:0] round_div(longint s, longint unsigned w);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag + w / 2) / w;
    if (s < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(64'h1_0000_0000 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic ncpe_out_t curve_point(logic [16:0] u_in);
    longint unsigned basis [MAX_DEGREE + 1];
    longint unsigned lft [MAX_DEGREE + 1];
    longint unsigned rgt [MAX_DEGREE + 1];
    longint unsigned u, wsum, saved, d, nold, nw;
    longint          sx, sy, a, b;
    int              n, p, span, idx;
    ncpe_out_t       res;
    n = clamp_count(mdl_count);
    p = clamp_degree(mdl_degree, n);
    u = u_in;
    if (u > 65536) u = 65536;
    wsum = 0;
    sx = 0;
    sy = 0;
    // u at one belongs to the last span
    if (u == 65536) span = n - 1;
    else begin
      span = p;
      for (int k = p; k <= n - 1; k++)
        if (knot_tab[k] <= u) span = k;
    end
    // cox-de boor in q.30
    basis[0] = 64'd1 << 30;
    for (int j = 1; j <= p; j++) begin
      a = longint'(u) - longint'(knot_tab[span + 1 - j]);
      b = longint'(knot_tab[span + j]) - longint'(u);
      saved = 0;
      lft[j] = (a > 0) ? a : 0;
      rgt[j] = (b > 0) ? b : 0;
      for (int r = 0; r < j; r++) begin
        d = rgt[r + 1] + lft[j - r];
        nold = basis[r];
        if (d == 0) begin
          basis[r] = saved;
          saved = 0;
        end else begin
          basis[r] = saved + (nold * rgt[r + 1]) / d;
          saved = (nold * lft[j - r]) / d;
        end
      end
      basis[j] = saved;
    end
    for (int k = 0; k <= p; k++) begin
      idx = span - p + k;
      nw = (basis[k] * pole_w_mem[idx]) >> 30;
      wsum += nw;
      sx += longint'(nw) * pole_x_mem[idx];
      sy += longint'(nw) * pole_y_mem[idx];
    end
    // zero weight sum gives the origin
    if (wsum == 0) begin
      res.point_x = '0;
      res.point_y = '0;
    end else begin
      res.point_x = round_div(sx, wsum);
      res.point_y = round_div(sy, wsum);
    end
    res.span_index = 6'(span);
    return res;
  endfunction

  task automatic apply_transfer(ncpe_in_t it);
    if (it.opcode == OPC_STORE) begin
      // slots at or above the pole count are dropped
      if (int'(it.pole_index) < clamp_count(mdl_count)) begin
        pole_x_mem[it.pole_index] = longint'(signed'(it.pole_x));
        pole_y_mem[it.pole_index] = longint'(signed'(it.pole_y));
        pole_w_mem[it.pole_index] = it.pole_weight;
      end
    end else begin
      point_q.push_back(curve_point(it.eval_u));
    end
  endtask

  task automatic apply_cfg(logic idx, logic [6:0] val);
    if (idx == CFG_DEGREE) mdl_degree = val[2:0];
    else mdl_count = val;
    rebuild_knots();
  endtask

  // ---------------------------------------------------------------
  // stimulus queue builders
  // ---------------------------------------------------------------
  int gen_items;
  int gen_n;
  logic [2:0] gen_deg;
  logic [6:0] gen_cnt;

  function automatic ncpe_in_t noise_item();
    ncpe_in_t it;
    it.opcode      = 1'($urandom);
    it.pole_index  = 6'($urandom);
    it.pole_x      = $urandom;
    it.pole_y      = $urandom;
    it.pole_weight = 24'($urandom_range(1, 24'hFFFFFF));
    it.eval_u      = 17'($urandom);
    return it;
  endfunction

  task automatic push_item(ncpe_in_t it);
    pend_t e;
    e.kind = ACT_ITEM;
    e.item = it;
    e.cfg_idx = 1'b0;
    e.cfg_val = '0;
    pend_q.push_back(e);
    gen_items++;
  endtask

  task automatic push_store(logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                            logic [23:0] w);
    ncpe_in_t it;
    it = noise_item();
    it.opcode = OPC_STORE;
    it.pole_index = idx;
    it.pole_x = x;
    it.pole_y = y;
    it.pole_weight = w;
    push_item(it);
  endtask

  task automatic push_eval(logic [16:0] u);
    ncpe_in_t it;
    it = noise_item();
    it.opcode = OPC_EVAL;
    it.eval_u = u;
    push_item(it);
  endtask

  task automatic push_marker(act_kind_t kind, logic idx, logic [6:0] val);
    pend_t e;
    e.kind = kind;
    e.item = '0;
    e.cfg_idx = idx;
    e.cfg_val = val;
    pend_q.push_back(e);
    if (kind == ACT_CFG) begin
      if (idx == CFG_DEGREE) gen_deg = val[2:0];
      else gen_cnt = val;
      gen_n = clamp_count(gen_cnt);
    end
  endtask

  function automatic logic [23:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 24'h010000;
      1: return 24'($urandom_range(1, 24'hFFFFFF));
      2: return 24'($urandom_range(24'h004000, 24'h040000));
      default: return 24'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [16:0] rand_u();
    case ($urandom_range(0, 9))
      0: return 17'h10000;
      1: return 17'($urandom_range(17'h10001, 17'h1FFFF));
      2: return 17'($urandom_range(0, 3));
      default: return 17'($urandom_range(0, 17'h10000));
    endcase
  endfunction

  // one setting: write registers, fill every live slot, then a random mix
  task automatic random_phase(logic [2:0] deg, logic [6:0] cnt, int mix);
    push_marker(ACT_CFG, CFG_DEGREE, {4'b0, deg});
    push_marker(ACT_CFG, CFG_POLES, cnt);
    for (int i = 0; i < gen_n; i++)
      push_store(6'(i), $urandom, $urandom, rand_weight());
    for (int i = 0; i < mix; i++) begin
      if ($urandom_range(0, 9) < 7) push_eval(rand_u());
      else push_store(6'($urandom), $urandom, $urandom, rand_weight());
      if ($urandom_range(0, 99) == 0) push_marker(ACT_DRAIN, 1'b0, '0);
    end
  endtask

  initial begin
    logic [2:0] deg;
    logic [6:0] cnt;
    gen_items = 0;
    gen_deg = 3'd3;
    gen_cnt = 7'd4;
    gen_n = 4;
    // directed: reset setting, degree 3 over 4 poles, extreme coordinates
    push_store(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
    push_store(6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 24'h000001);
    push_store(6'd2, 32'h0000_0000, 32'hFFFF_FFFF, 24'h010000);
    push_store(6'd3, 32'hFFFF_FFFF, 32'h0000_0000, 24'h800000);
    push_store(6'd4, 32'h1234_5678, 32'h1234_5678, 24'h010000); // dropped slot
    push_store(6'd63, 32'h5555_5555, 32'hAAAA_AAAA, 24'h010000);
    push_eval(17'h00000);
    push_eval(17'h10000);
    push_eval(17'h1FFFF);   // clipped to one
    push_eval(17'h10001);
    push_eval(17'h00001);
    push_eval(17'h08000);
    push_eval(17'h0FFFF);
    // tiny weights: weighted sum collapses to zero
    for (int i = 0; i < 4; i++)
      push_store(6'(i), $urandom, $urandom, 24'h000001);
    push_eval(17'h08000);
    push_eval(17'h05555);
    push_marker(ACT_DRAIN, 1'b0, '0);
    push_store(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
    push_eval(17'h02000);
    // register extremes, then random settings
    random_phase(3'd7, 7'd64, 12);
    random_phase(3'd0, 7'd2, 30);
    random_phase(3'd7, 7'd127, 8);
    random_phase(3'd5, 7'd0, 20);
    random_phase(3'd2, 7'd1, 20);
    random_phase(3'd7, 7'd8, 20);
    while (gen_items < ITEM_TARGET) begin
      deg = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3))
                                       : 3'($urandom_range(4, 7));
      cnt = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(2, 12));
      random_phase(deg, cnt, 25 + $urandom_range(0, 30));
    end
  end

  // ---------------------------------------------------------------
  // driver: pops the pending queue, predicts on each transfer
  // ---------------------------------------------------------------
  int   gap_left;
  int   quiet_cnt;
  logic burst_mode;

  always @(posedge clk) begin
    logic  nxt_start;
    logic  nxt_we;
    pend_t e;
    if (!rst_n) begin
      start      <= 1'b0;
      cfg_we     <= 1'b0;
      cfg_index  <= 1'b0;
      cfg_data   <= '0;
      in_data    <= '0;
      gap_left   <= 0;
      quiet_cnt  <= 0;
      burst_mode <= 1'b0;
      mdl_degree = 3'd3;
      mdl_count  = 7'd4;
      rebuild_knots();
    end else begin
      nxt_start = 1'b0;
      nxt_we    = 1'b0;
      // settle counter, runs only while nothing is outstanding
      if (point_q.size() == 0 && !busy && !start) quiet_cnt <= quiet_cnt + 1;
      else quiet_cnt <= 0;
      if (start && !busy) apply_transfer(in_data);
      if (start && busy) begin
        nxt_start = 1'b1;       // hold until the block takes it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        e = pend_q[0];
        case (e.kind)
          ACT_ITEM: begin
            in_data <= e.item;
            nxt_start = 1'b1;
            void'(pend_q.pop_front());
            if ($urandom_range(0, 49) == 0) burst_mode <= ~burst_mode;
            gap_left <= burst_mode ? 0 : $urandom_range(0, 9);
          end
          ACT_CFG: begin
            // registers only change once the block has gone quiet
            if (quiet_cnt >= SETTLE_CYCLES && !(start && !busy)) begin
              nxt_we = 1'b1;
              cfg_index <= e.cfg_idx;
              cfg_data  <= e.cfg_val;
              apply_cfg(e.cfg_idx, e.cfg_val);
              void'(pend_q.pop_front());
            end
          end
          default: begin
            // hold off until every outstanding point is back
            if (point_q.size() == 0 && !(start && !busy)) void'(pend_q.pop_front());
          end
        endcase
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // ---------------------------------------------------------------
  // monitor: one-cycle result strobe against the oldest prediction
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    ncpe_out_t want;
    if (rst_n && out_valid) begin
      if (point_q.size() == 0) begin
        fail_cnt++;
        $display("unexpected point x=%h y=%h span=%0d", out_data.point_x,
                 out_data.point_y, out_data.span_index);
      end else begin
        want = point_q.pop_front();
        if (out_data.point_x !== want.point_x || out_data.point_y !== want.point_y ||
            out_data.span_index !== want.span_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp x=%h y=%h span=%0d got x=%h y=%h span=%0d",
                     want.point_x, want.point_y, want.span_index, out_data.point_x,
                     out_data.point_y, out_data.span_index);
        end
      end
    end
  end

  // reset and end of run
  initial begin
    mismatches = 0;
    fail_cnt = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pend_q.size() > 0 || start || busy || point_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (point_q.size() > 0) fail_cnt++;
    if (mismatches == 0 && fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #150_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ncpe_pkg.sv
hdl/ncpe_div.sv
hdl/ncpe_ctrl.sv
hdl/ncpe_dp.sv
hdl/nurbs_curve_point_evaluator.sv
tb/sv/tb_top.sv
